// ===== rtl/core/lease_table_dual_key_lookup_unit_macros.svh =====
// Assertion macros shared by the lease table RTL.
// The checks compile away when SYNTH is defined.
`ifndef LEASE_TABLE_DUAL_KEY_LOOKUP_UNIT_MACROS_SVH
`define LEASE_TABLE_DUAL_KEY_LOOKUP_UNIT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define LTDK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lease table check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define LTDK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lease table check failed: next-cycle implication");

`else

`define LTDK_ASSERT_NOW(label, clk, rst, ante, cons)
`define LTDK_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/ltdk_pkg.sv =====
package ltdk_pkg;

  // Command codes carried on the input channel.
  localparam logic [1:0] CMD_RECORD      = 2'd0;
  localparam logic [1:0] CMD_FIND_BY_HW  = 2'd1;
  localparam logic [1:0] CMD_FIND_BY_NET = 2'd2;

  localparam int HW_W  = 48;
  localparam int NET_W = 32;

  // One lease slot as held in the slot memory.
  typedef struct packed {
    logic [HW_W-1:0]  hw;
    logic [NET_W-1:0] net;
  } ltdk_entry_t;

  // Lookup result handed from the scan controller to the output stage.
  typedef struct packed {
    logic             found;
    logic [HW_W-1:0]  hw;
    logic [NET_W-1:0] net;
  } ltdk_result_t;

endpackage

// ===== rtl/core/ltdk_mem.sv =====
module ltdk_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  ltdk_pkg::ltdk_entry_t wr_data,
  input  logic [ADDR_W-1:0]    rd_addr,
  output ltdk_pkg::ltdk_entry_t rd_data
);
  import ltdk_pkg::*;

  ltdk_entry_t mem [DEPTH];

  // Single write port, single read port with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/ltdk_ctrl.sv =====
`include "lease_table_dual_key_lookup_unit_macros.svh"

module ltdk_ctrl #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [ltdk_pkg::HW_W-1:0]   hw_address,
  input  logic [ltdk_pkg::NET_W-1:0]  net_address,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ltdk_pkg::ltdk_result_t      res,
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output ltdk_pkg::ltdk_entry_t       wr_data,
  output logic [ADDR_W-1:0]           rd_addr,
  input  ltdk_pkg::ltdk_entry_t       rd_data
);
  import ltdk_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  logic              state;
  logic              state_next;
  logic [DEPTH-1:0]  slot_valid;
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] cnt;
  logic              by_hw;
  logic [HW_W-1:0]   key_hw;
  logic [NET_W-1:0]  key_net;

  logic in_accept;
  logic is_lookup;
  logic key_match;
  logic hit;
  logic done;
  logic advance;

  // Input side: one beat at a time, taken only while no scan is running.
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_lookup = (command == CMD_FIND_BY_HW) || (command == CMD_FIND_BY_NET);

  // Record writes straight into the slot named by the ring pointer.
  assign wr_en   = in_accept && (command == CMD_RECORD);
  assign wr_addr = wr_ptr;
  assign wr_data = '{hw: hw_address, net: net_address};

  // Compare the entry whose read data has just arrived.
  assign key_match = by_hw ? (rd_data.hw == key_hw) : (rd_data.net == key_net);
  assign hit       = slot_valid[cnt] && key_match;
  assign done      = hit || (cnt == LAST);
  assign advance   = (state == ST_SCAN) && !done;

  assign res_valid = (state == ST_SCAN) && done;
  assign res.found = hit;
  assign res.hw    = hit ? rd_data.hw : '0;
  assign res.net   = hit ? rd_data.net : '0;

  // Read the next slot while scanning; hold the current one while the result waits.
  always_comb begin
    if (state == ST_SCAN) begin
      rd_addr = advance ? (cnt + ADDR_W'(1)) : cnt;
    end else begin
      rd_addr = '0;
    end
  end

  // State transitions.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && is_lookup) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (res_valid && res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      wr_ptr     <= '0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        slot_valid[wr_ptr] <= 1'b1;
        wr_ptr <= (wr_ptr == LAST) ? '0 : (wr_ptr + ADDR_W'(1));
      end
      if (in_accept && is_lookup) begin
        cnt <= '0;
      end else if (advance) begin
        cnt <= cnt + ADDR_W'(1);
      end
    end
  end

  // Search key, captured with the lookup beat.
  always_ff @(posedge clk) begin
    if (in_accept && is_lookup) begin
      by_hw   <= (command == CMD_FIND_BY_HW);
      key_hw  <= hw_address;
      key_net <= net_address;
    end
  end

  `LTDK_ASSERT_NEXT(a_record_sets_valid, clk, rst, wr_en, slot_valid[$past(wr_ptr)])
  `LTDK_ASSERT_NOW(a_hit_matches_key, clk, rst, res_valid && res.found,
                   (by_hw && res.hw == key_hw) || (!by_hw && res.net == key_net))
  `LTDK_ASSERT_NOW(a_no_write_in_scan, clk, rst, state == ST_SCAN, !wr_en && in_stall)

endmodule

// ===== rtl/core/ltdk_out.sv =====
module ltdk_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_valid,
  output logic                        res_ready,
  input  ltdk_pkg::ltdk_result_t      res,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [ltdk_pkg::HW_W-1:0]   match_hw_address,
  output logic [ltdk_pkg::NET_W-1:0]  match_net_address
);
  import ltdk_pkg::*;

  // The register can take a new beat when empty or when its beat leaves now.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // Payload is loaded only with a new beat, so a stalled beat holds.
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      found             <= res.found;
      match_hw_address  <= res.hw;
      match_net_address <= res.net;
    end
  end

endmodule

// ===== rtl/core/lease_table_dual_key_lookup_unit.sv =====
// Lease table: pairs of 48-bit hardware and 32-bit network addresses.
// Input channel (in_valid / in_stall) carries command, hw_address and
// net_address. A record beat writes the pair into the slot at the ring
// pointer, overwriting the oldest slot once the table is full; it gives no
// result. Command code 3 is dropped without effect. A lookup beat scans
// the slots one per cycle through the slot memory read port, stopping at
// the lowest valid match. One result beat follows on the output channel
// (out_valid / out_stall): found plus both addresses, zero on a miss. The
// input is stalled for the whole scan, so no new beat is taken until the
// lookup's result has left the controller. While the receiver stalls, the
// result sits in the output register and a further finished scan waits in
// the controller, holding the input stalled. Reset clears all valid marks
// and the ring pointer.
module lease_table_dual_key_lookup_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [ltdk_pkg::HW_W-1:0]   hw_address,
  input  logic [ltdk_pkg::NET_W-1:0]  net_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [ltdk_pkg::HW_W-1:0]   match_hw_address,
  output logic [ltdk_pkg::NET_W-1:0]  match_net_address
);
  import ltdk_pkg::*;

  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  ltdk_entry_t       wr_data;
  logic [ADDR_W-1:0] rd_addr;
  ltdk_entry_t       rd_data;
  logic              res_valid;
  logic              res_ready;
  ltdk_result_t      res;

  // Slot contents.
  ltdk_mem #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Valid marks, ring pointer and the scan sequencer.
  ltdk_ctrl #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .hw_address  (hw_address),
    .net_address (net_address),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // Result register on the output channel.
  ltdk_out u_out (
    .clk               (clk),
    .rst               (rst),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res               (res),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .found             (found),
    .match_hw_address  (match_hw_address),
    .match_net_address (match_net_address)
  );

endmodule

// ===== tb/tb_lease_table_dual_key_lookup_unit.sv =====
`timescale 1ns / 100ps

module tb_lease_table_dual_key_lookup_unit;
  import ltdk_pkg::*;

  localparam int SLOTS = 16;
  localparam int RAND_ITEMS = 900;
  localparam int PRESS_AT = 300;
  localparam int PRESS_SPAN = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_FROM = RAND_ITEMS - 120;
  localparam int DRAIN = SLOTS + 4;
  localparam int LIMIT = 300000;
  localparam int HISTORY = 24;

  // Command code 3 is not used by the block and must be dropped.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [HW_W-1:0] HW_ONES = '1;
  localparam logic [NET_W-1:0] NET_ONES = '1;
  localparam logic [HW_W-1:0] HW_FIVES = 48'h5555_5555_5555;
  localparam logic [HW_W-1:0] HW_TENS = 48'hAAAA_AAAA_AAAA;
  localparam logic [NET_W-1:0] NET_FIVES = 32'h5555_5555;
  localparam logic [NET_W-1:0] NET_TENS = 32'hAAAA_AAAA;
  localparam ltdk_result_t MISS = '0;

  // One directed beat, with its answer written out where it is obvious.
  typedef struct packed {
    logic [1:0]       cmd;
    logic [HW_W-1:0]  hw;
    logic [NET_W-1:0] net;
    logic             typed;
    ltdk_result_t     want;
  } probe_row_t;

  localparam int PROBES = 19;
  localparam probe_row_t PROBE_TABLE [PROBES] = '{
    // Empty table: every lookup misses.
    '{CMD_FIND_BY_HW,  48'h0,    32'h0,     1'b1, MISS},
    '{CMD_FIND_BY_NET, HW_ONES,  NET_ONES,  1'b1, MISS},
    // The unused code must not record anything.
    '{CMD_UNUSED,      HW_ONES,  NET_ONES,  1'b0, MISS},
    '{CMD_FIND_BY_HW,  HW_ONES,  32'h0,     1'b1, MISS},
    // All-ones lease in slot 0.
    '{CMD_RECORD,      HW_ONES,  NET_ONES,  1'b0, MISS},
    '{CMD_FIND_BY_HW,  HW_ONES,  32'h0,     1'b1, '{1'b1, HW_ONES, NET_ONES}},
    '{CMD_FIND_BY_NET, 48'h0,    NET_ONES,  1'b1, '{1'b1, HW_ONES, NET_ONES}},
    // All-zero lease in slot 1: a hit with zero addresses.
    '{CMD_RECORD,      48'h0,    32'h0,     1'b0, MISS},
    '{CMD_FIND_BY_HW,  48'h0,    NET_ONES,  1'b1, '{1'b1, 48'h0, 32'h0}},
    '{CMD_FIND_BY_NET, HW_ONES,  32'h0,     1'b1, '{1'b1, 48'h0, 32'h0}},
    // Duplicate hardware address in slot 2: the lower slot wins.
    '{CMD_RECORD,      48'h0,    NET_FIVES, 1'b0, MISS},
    '{CMD_FIND_BY_HW,  48'h0,    NET_FIVES, 1'b1, '{1'b1, 48'h0, 32'h0}},
    // Duplicate network address in slot 3: the lower slot wins.
    '{CMD_RECORD,      HW_FIVES, 32'h0,     1'b0, MISS},
    '{CMD_FIND_BY_NET, HW_TENS,  32'h0,     1'b1, '{1'b1, 48'h0, 32'h0}},
    '{CMD_FIND_BY_NET, 48'h0,    NET_FIVES, 1'b1, '{1'b1, 48'h0, NET_FIVES}},
    // The key on the other field must not match.
    '{CMD_FIND_BY_HW,  HW_TENS,  NET_FIVES, 1'b1, MISS},
    '{CMD_FIND_BY_NET, HW_FIVES, NET_TENS,  1'b1, MISS},
    '{CMD_UNUSED,      HW_TENS,  32'h0,     1'b0, MISS},
    '{CMD_FIND_BY_HW,  HW_FIVES, 32'h0,     1'b1, '{1'b1, HW_FIVES, 32'h0}}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       command = CMD_RECORD;
  logic [HW_W-1:0]  hw_address = '0;
  logic [NET_W-1:0] net_address = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             found;
  logic [HW_W-1:0]  match_hw_address;
  logic [NET_W-1:0] match_net_address;

  // Answer written out for the beat on offer, travelling with its payload.
  logic             typed_flag = 1'b0;
  ltdk_result_t     typed_res = MISS;

  // Requests from the sender to the receiver process.
  logic             hold_req = 1'b0;
  logic             quiet = 1'b0;

  // Shadow copy of the lease table.
  logic             lease_live [SLOTS];
  logic [HW_W-1:0]  lease_hw [SLOTS];
  logic [NET_W-1:0] lease_net [SLOTS];
  int               ring_slot;

  ltdk_result_t     answers_due [$];
  int               fault_count = 0;
  int               cycle_count = 0;

  // Leases recorded lately, used as keys so that lookups hit.
  logic [HW_W-1:0]  recent_hw [$];
  logic [NET_W-1:0] recent_net [$];

  int               hold_left = 0;
  bit               hold_done = 1'b0;
  int               rx_busy = 0;
  int               rx_free = 0;

  lease_table_dual_key_lookup_unit #(
    .TABLE_ENTRIES(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .hw_address(hw_address),
    .net_address(net_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found(found),
    .match_hw_address(match_hw_address),
    .match_net_address(match_net_address)
  );

  always #5 clk = ~clk;

  // Writes a lease at the ring position and moves the ring on.
  function automatic void store_lease(logic [HW_W-1:0] hw, logic [NET_W-1:0] net);
    lease_live[ring_slot] = 1'b1;
    lease_hw[ring_slot] = hw;
    lease_net[ring_slot] = net;
    ring_slot = (ring_slot + 1 >= SLOTS) ? 0 : ring_slot + 1;
  endfunction

  // Finds the lowest live slot whose chosen key matches.
  function automatic ltdk_result_t search_leases(logic [1:0] cmd, logic [HW_W-1:0] hw,
                                                 logic [NET_W-1:0] net);
    ltdk_result_t res;
    bit hit;
    res = MISS;
    for (int i = 0; i < SLOTS; i++) begin
      hit = (cmd == CMD_FIND_BY_HW) ? (lease_hw[i] == hw) : (lease_net[i] == net);
      if (lease_live[i] && hit) begin
        res = '{1'b1, lease_hw[i], lease_net[i]};
        break;
      end
    end
    return res;
  endfunction

  // Hardware address with a bias towards a few shared values and the extremes.
  function automatic logic [HW_W-1:0] pick_hw();
    logic [63:0] raw;
    int r;
    raw = {$urandom, $urandom};
    r = $urandom_range(0, 9);
    if (r == 0) return HW_W'($urandom_range(0, 3));
    if (r == 1) return HW_ONES;
    return raw[HW_W-1:0];
  endfunction

  function automatic logic [NET_W-1:0] pick_net();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return NET_W'($urandom_range(0, 3));
    if (r == 1) return NET_ONES;
    return $urandom;
  endfunction

  // Puts one beat on the input and waits until the block takes it.
  task automatic offer_beat(input logic [1:0] cmd, input logic [HW_W-1:0] hw,
                            input logic [NET_W-1:0] net, input logic use_typed,
                            input ltdk_result_t want);
    in_valid <= 1'b1;
    command <= cmd;
    hw_address <= hw;
    net_address <= net;
    typed_flag <= use_typed;
    typed_res <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sometimes drops valid for a short burst after a beat.
  task automatic sender_pause(input bit allow);
    int n;
    if (allow && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Predictor and result checker, both on the accepted beats.
  always @(posedge clk) begin : track_beats
    ltdk_result_t got;
    ltdk_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {found, match_hw_address, match_net_address};
        if (answers_due.size() == 0) begin
          $display("%0t ns: result beat with no lookup pending, found %0b hw %h net %h",
                   $time, got.found, got.hw, got.net);
          fault_count++;
        end else begin
          want = answers_due.pop_front();
          if (got.found !== want.found) begin
            $display("%0t ns: found expected %0b, got %0b", $time, want.found, got.found);
            fault_count++;
          end
          if (got.hw !== want.hw) begin
            $display("%0t ns: match_hw_address expected %h, got %h", $time, want.hw, got.hw);
            fault_count++;
          end
          if (got.net !== want.net) begin
            $display("%0t ns: match_net_address expected %h, got %h", $time, want.net,
                     got.net);
            fault_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (command)
          CMD_RECORD: store_lease(hw_address, net_address);
          CMD_FIND_BY_HW, CMD_FIND_BY_NET: begin
            want = search_leases(command, hw_address, net_address);
            answers_due.push_back(typed_flag ? typed_res : want);
          end
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, and none at the end.
  always @(posedge clk) begin : drive_out_stall
    int n;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (rx_busy != 0) begin
      out_stall <= 1'b1;
      rx_busy <= rx_busy - 1;
    end else if (rx_free != 0) begin
      out_stall <= 1'b0;
      rx_free <= rx_free - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 11);
      out_stall <= 1'b1;
      rx_busy <= n - 1;
    end else begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      out_stall <= 1'b0;
      rx_free <= n - 1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("%0t ns: run did not finish within %0d cycles", $time, LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [1:0] cmd;
    logic [HW_W-1:0] hw;
    logic [NET_W-1:0] net;
    int sent;
    int r;
    int k;
    bit busy_phase;

    for (int i = 0; i < SLOTS; i++) begin
      lease_live[i] = 1'b0;
      lease_hw[i] = '0;
      lease_net[i] = '0;
    end
    ring_slot = 0;

    // Apply reset, then release it.
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats from the table.
    for (int i = 0; i < PROBES; i++) begin
      offer_beat(PROBE_TABLE[i].cmd, PROBE_TABLE[i].hw, PROBE_TABLE[i].net,
                 PROBE_TABLE[i].typed, PROBE_TABLE[i].want);
      sender_pause(1'b1);
    end

    // Random beats: mostly records and lookups keyed from recent leases.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent == PRESS_AT) hold_req <= 1'b1;
      if (sent == QUIET_FROM) quiet <= 1'b1;
      busy_phase = (sent >= PRESS_AT && sent < PRESS_AT + PRESS_SPAN) || sent >= QUIET_FROM;

      r = $urandom_range(0, 99);
      if (r < 4) cmd = CMD_UNUSED;
      else if (r < 40) cmd = CMD_RECORD;
      else if (r < 70) cmd = CMD_FIND_BY_HW;
      else cmd = CMD_FIND_BY_NET;
      hw = pick_hw();
      net = pick_net();

      if (cmd == CMD_RECORD) begin
        // Now and then reuse one key of an earlier lease to make duplicates.
        if (recent_hw.size() != 0 && $urandom_range(0, 4) == 0) begin
          k = $urandom_range(0, recent_hw.size() - 1);
          if ($urandom_range(0, 1)) hw = recent_hw[k];
          else net = recent_net[k];
        end
        recent_hw.push_back(hw);
        recent_net.push_back(net);
        if (recent_hw.size() > HISTORY) begin
          void'(recent_hw.pop_front());
          void'(recent_net.pop_front());
        end
      end else if (cmd != CMD_UNUSED && recent_hw.size() != 0 &&
                   $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, recent_hw.size() - 1);
        if (cmd == CMD_FIND_BY_HW) hw = recent_hw[k];
        else net = recent_net[k];
      end

      offer_beat(cmd, hw, net, 1'b0, MISS);
      if (cmd != CMD_UNUSED) sent++;
      sender_pause(!busy_phase);
    end

    // Drain: wait for every lookup answer before the final report.
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
